FILE: hdl/pio_pkg.sv
package pio_pkg;

    // default store geometry
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // inset decimation and placement
    localparam int SCALE       = 4;
    localparam int SCALE_LOG2  = $clog2(SCALE);
    localparam int EDGE_MARGIN = 10;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // field widths
    localparam int DIM_W     = 11;
    localparam int POS_W     = 10;
    localparam int SAMPLE_W  = 8;
    localparam int PLANE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int OFFS_W    = 13;

    // plane codes, also used to select an inset store
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // request types
    localparam logic REQ_INSET = 1'b0;
    localparam logic REQ_MAIN  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // frame geometry seen by the front
    typedef struct packed {
        logic [DIM_W-1:0]         width;
        logic [DIM_W-1:0]         height;
        logic signed [OFFS_W-1:0] row_offset;
    } pio_cfg_t;

    // one classified operation for the back
    typedef struct packed {
        logic                is_main;
        logic                wr_en;
        logic                hit;
        logic [PLANE_W-1:0]  store_sel;
        logic [SAMPLE_W-1:0] sample;
        logic [PLANE_W-1:0]  plane;
    } pio_op_t;

    // back status toward the top level
    typedef struct packed {
        logic present;
        logic read_busy;
    } pio_status_t;

    // first luma row of the inset region: h - h/scale - margin
    function automatic logic signed [OFFS_W-1:0] pio_row_offset(input logic [DIM_W-1:0] h);
        logic [OFFS_W-1:0] h_ext;
        h_ext = OFFS_W'(h);
        return $signed(h_ext - (h_ext >> SCALE_LOG2) - OFFS_W'(EDGE_MARGIN));
    endfunction

endpackage

FILE: hdl/pio_front.sv
module pio_front
    import pio_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int ADDR_W     = 16
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [PLANE_W-1:0]  s_plane,
    input  logic [POS_W-1:0]    s_x_pos,
    input  logic [POS_W-1:0]    s_y_pos,
    input  logic [SAMPLE_W-1:0] s_sample_in,
    input  pio_cfg_t            cfg,
    input  logic                queue_full,
    output logic                push,
    output pio_op_t             push_op,
    output logic [ADDR_W-1:0]   push_addr
);

    localparam int LumaStride   = MAX_WIDTH / SCALE;
    localparam int LumaRows     = MAX_HEIGHT / SCALE;
    localparam int ChromaStride = MAX_WIDTH / (2 * SCALE);
    localparam int ChromaRows   = MAX_HEIGHT / (2 * SCALE);

    // inset region test on half-resolution offsets
    function automatic logic in_region(input logic [OFFS_W-1:0] i,
                                       input logic [OFFS_W-1:0] j,
                                       input logic [OFFS_W-1:0] w,
                                       input logic [OFFS_W-1:0] h,
                                       input logic [OFFS_W-1:0] hoff);
        return (i < (w >> (SCALE_LOG2 + 1))) &&
               ((OFFS_W'(EDGE_MARGIN) + {i[OFFS_W-2:0], 1'b0}) < w) &&
               (j < (h >> (SCALE_LOG2 + 1))) &&
               ((hoff + {j[OFFS_W-2:0], 1'b0}) < h);
    endfunction

    logic [OFFS_W-1:0] x_e, y_e, w_e, h_e, hoff_u;
    logic              hoff_neg;
    logic              st_luma_ok, st_chroma_ok, lk_luma_ok, lk_chroma_ok;
    logic [OFFS_W-1:0] lx, ly, cx, cy;
    logic [OFFS_W-1:0] ldx, ldy, cdx, cdy;
    logic [ADDR_W-1:0] st_luma_addr, st_chroma_addr, lk_luma_addr, lk_chroma_addr;

    assign x_e      = OFFS_W'(s_x_pos);
    assign y_e      = OFFS_W'(s_y_pos);
    assign w_e      = OFFS_W'(cfg.width);
    assign h_e      = OFFS_W'(cfg.height);
    assign hoff_u   = $unsigned(cfg.row_offset);
    assign hoff_neg = cfg.row_offset[OFFS_W-1];

    // inset luma: keep the first two of every 2*scale columns and rows
    assign lx = ((x_e >> (SCALE_LOG2 + 1)) << 1) | OFFS_W'(s_x_pos[0]);
    assign ly = ((y_e >> (SCALE_LOG2 + 1)) << 1) | OFFS_W'(s_y_pos[0]);
    assign st_luma_ok = (x_e < w_e) && (y_e < h_e) &&
                        (s_x_pos[SCALE_LOG2:1] == '0) && (s_y_pos[SCALE_LOG2:1] == '0) &&
                        (lx < OFFS_W'(LumaStride)) && (ly < OFFS_W'(LumaRows));
    assign st_luma_addr = ADDR_W'(32'(ly) * 32'(LumaStride) + 32'(lx));

    // inset chroma: keep every scale-th column and row
    assign cx = x_e >> SCALE_LOG2;
    assign cy = y_e >> SCALE_LOG2;
    assign st_chroma_ok = (x_e < ((w_e + OFFS_W'(1)) >> 1)) &&
                          (y_e < ((h_e + OFFS_W'(1)) >> 1)) &&
                          (s_x_pos[SCALE_LOG2-1:0] == '0) && (s_y_pos[SCALE_LOG2-1:0] == '0) &&
                          (cx < OFFS_W'(ChromaStride)) && (cy < OFFS_W'(ChromaRows));
    assign st_chroma_addr = ADDR_W'(32'(cy) * 32'(ChromaStride) + 32'(cx));

    // main luma lookup
    assign ldx = x_e - OFFS_W'(EDGE_MARGIN);
    assign ldy = y_e - hoff_u;
    assign lk_luma_ok = !hoff_neg && (x_e < w_e) && (y_e < h_e) &&
                        (x_e >= OFFS_W'(EDGE_MARGIN)) && (y_e >= hoff_u) &&
                        in_region(ldx >> 1, ldy >> 1, w_e, h_e, hoff_u) &&
                        (ldx < OFFS_W'(LumaStride)) && (ldy < OFFS_W'(LumaRows));
    assign lk_luma_addr = ADDR_W'(32'(ldy) * 32'(LumaStride) + 32'(ldx));

    // main chroma lookup
    assign cdx = x_e - OFFS_W'(EDGE_MARGIN / 2);
    assign cdy = y_e - (hoff_u >> 1);
    assign lk_chroma_ok = !hoff_neg &&
                          (x_e >= OFFS_W'(EDGE_MARGIN / 2)) && (y_e >= (hoff_u >> 1)) &&
                          in_region(cdx, cdy, w_e, h_e, hoff_u) &&
                          (cdx < OFFS_W'(ChromaStride)) && (cdy < OFFS_W'(ChromaRows));
    assign lk_chroma_addr = ADDR_W'(32'(cdy) * 32'(ChromaStride) + 32'(cdx));

    // classify the transaction
    always_comb begin
        push_op.is_main   = (s_req_type == REQ_MAIN);
        push_op.sample    = s_sample_in;
        push_op.plane     = s_plane;
        push_op.store_sel = s_plane;
        case (s_plane)
            PLANE_Y: begin
                push_op.wr_en = (s_req_type == REQ_INSET) && st_luma_ok;
                push_op.hit   = (s_req_type == REQ_MAIN) && lk_luma_ok;
                push_addr     = (s_req_type == REQ_MAIN) ? lk_luma_addr : st_luma_addr;
            end
            PLANE_U, PLANE_V: begin
                push_op.wr_en = (s_req_type == REQ_INSET) && st_chroma_ok;
                push_op.hit   = (s_req_type == REQ_MAIN) && lk_chroma_ok;
                push_addr     = (s_req_type == REQ_MAIN) ? lk_chroma_addr : st_chroma_addr;
            end
            default: begin
                push_op.wr_en     = 1'b0;
                push_op.hit       = 1'b0;
                push_op.store_sel = PLANE_Y;
                push_addr         = '0;
            end
        endcase
    end

    // dropped inset samples never enter the queue
    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready && (push_op.is_main || push_op.wr_en);

endmodule

FILE: hdl/pio_queue.sv
module pio_queue
    import pio_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CntW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/pio_back.sv
module pio_back
    import pio_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int ADDR_W     = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  pio_op_t             head_op,
    input  logic [ADDR_W-1:0]   head_addr,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_sample_out,
    output logic                m_from_inset,
    output logic [PLANE_W-1:0]  m_out_plane,
    output pio_status_t         status
);

    localparam int LumaDepth   = (MAX_WIDTH / SCALE) * (MAX_HEIGHT / SCALE);
    localparam int ChromaDepth = (MAX_WIDTH / (2 * SCALE)) * (MAX_HEIGHT / (2 * SCALE));
    localparam int ChromaAddrW = $clog2(ChromaDepth);

    logic [SAMPLE_W-1:0] luma_mem [LumaDepth];
    logic [SAMPLE_W-1:0] u_mem    [ChromaDepth];
    logic [SAMPLE_W-1:0] v_mem    [ChromaDepth];
    logic [SAMPLE_W-1:0] luma_rd_reg, u_rd_reg, v_rd_reg;

    logic [ChromaAddrW-1:0] chroma_addr;
    logic                   out_free, do_write, do_read;

    logic                present_reg, present_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_replace_reg, rd_replace_next;
    logic [PLANE_W-1:0]  rd_sel_reg, rd_sel_next;
    logic [SAMPLE_W-1:0] rd_sample_reg, rd_sample_next;
    logic [PLANE_W-1:0]  rd_plane_reg, rd_plane_next;
    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] m_sample_reg, m_sample_next;
    logic                m_from_inset_reg, m_from_inset_next;
    logic [PLANE_W-1:0]  m_plane_reg, m_plane_next;
    logic [SAMPLE_W-1:0] rd_data;

    // issue when the head is a store write or the read stage can move on
    assign out_free    = !m_valid_reg || m_ready;
    assign pop         = head_valid && (head_op.wr_en || !rd_valid_reg || out_free);
    assign do_write    = pop && head_op.wr_en;
    assign do_read     = pop && head_op.is_main && head_op.hit;
    assign chroma_addr = head_addr[ChromaAddrW-1:0];

    // inset stores, one access per cycle each
    always_ff @(posedge aclk) begin
        if (do_write && (head_op.store_sel == PLANE_Y)) begin
            luma_mem[head_addr] <= head_op.sample;
        end
        if (do_read && (head_op.store_sel == PLANE_Y)) begin
            luma_rd_reg <= luma_mem[head_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write && (head_op.store_sel == PLANE_U)) begin
            u_mem[chroma_addr] <= head_op.sample;
        end
        if (do_read && (head_op.store_sel == PLANE_U)) begin
            u_rd_reg <= u_mem[chroma_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write && (head_op.store_sel == PLANE_V)) begin
            v_mem[chroma_addr] <= head_op.sample;
        end
        if (do_read && (head_op.store_sel == PLANE_V)) begin
            v_rd_reg <= v_mem[chroma_addr];
        end
    end

    // read data select
    always_comb begin
        case (rd_sel_reg)
            PLANE_Y: rd_data = luma_rd_reg;
            PLANE_U: rd_data = u_rd_reg;
            PLANE_V: rd_data = v_rd_reg;
            default: rd_data = luma_rd_reg;
        endcase
    end

    // read stage and output register
    always_comb begin
        present_next      = present_reg || do_write;
        rd_valid_next     = rd_valid_reg;
        rd_replace_next   = rd_replace_reg;
        rd_sel_next       = rd_sel_reg;
        rd_sample_next    = rd_sample_reg;
        rd_plane_next     = rd_plane_reg;
        m_valid_next      = m_valid_reg;
        m_sample_next     = m_sample_reg;
        m_from_inset_next = m_from_inset_reg;
        m_plane_next      = m_plane_reg;
        if (out_free) begin
            m_valid_next  = rd_valid_reg;
            rd_valid_next = 1'b0;
            if (rd_valid_reg) begin
                m_sample_next     = rd_replace_reg ? rd_data : rd_sample_reg;
                m_from_inset_next = rd_replace_reg;
                m_plane_next      = rd_plane_reg;
            end
        end
        if (pop && head_op.is_main) begin
            rd_valid_next   = 1'b1;
            rd_replace_next = head_op.hit && present_reg;
            rd_sel_next     = head_op.store_sel;
            rd_sample_next  = head_op.sample;
            rd_plane_next   = head_op.plane;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            present_reg  <= present_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_replace_reg   <= rd_replace_next;
        rd_sel_reg       <= rd_sel_next;
        rd_sample_reg    <= rd_sample_next;
        rd_plane_reg     <= rd_plane_next;
        m_sample_reg     <= m_sample_next;
        m_from_inset_reg <= m_from_inset_next;
        m_plane_reg      <= m_plane_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_sample_out     = m_sample_reg;
    assign m_from_inset     = m_from_inset_reg;
    assign m_out_plane      = m_plane_reg;
    assign status.present   = present_reg;
    assign status.read_busy = rd_valid_reg;

endmodule

FILE: hdl/pip_inset_overlay.sv
// Picture-in-picture overlay for planar YUV 4:2:0, one sample per transaction.
// Inset samples (req_type 0) are decimated and written into three on-chip
// stores (luma, U, V) and return nothing; main samples (req_type 1) return one
// sample each, replaced from the inset store inside the inset region once any
// inset sample has been kept. The block sustains one sample per clock unless
// the result side stalls: each sample needs a single access to one single-port
// inset store. A main sample's result goes through the queue, read stage and
// output register to the m_ channel; a four-entry queue between the classifying
// front and the store/output back lets either side stall alone. The stores are
// not cleared at reset, so a region lookup is only meaningful after the matching
// inset entry is written. The user must write frame width and height through
// the cfg_ port while no samples are in flight; the block does not enforce this.
module pip_inset_overlay
    import pio_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [PLANE_W-1:0]   s_plane,
    input  logic [POS_W-1:0]     s_x_pos,
    input  logic [POS_W-1:0]     s_y_pos,
    input  logic [SAMPLE_W-1:0]  s_sample_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [SAMPLE_W-1:0]  m_sample_out,
    output logic                 m_from_inset,
    output logic [PLANE_W-1:0]   m_out_plane
);

    localparam int AddrW  = $clog2((MAX_WIDTH / SCALE) * (MAX_HEIGHT / SCALE));
    localparam int QDataW = $bits(pio_op_t) + AddrW;

    logic [DIM_W-1:0]         width_reg, width_next;
    logic [DIM_W-1:0]         height_reg, height_next;
    logic signed [OFFS_W-1:0] row_offset_reg, row_offset_next;
    pio_cfg_t                 cfg;

    logic              push, pop, q_full, q_empty;
    pio_op_t           push_op, head_op;
    logic [AddrW-1:0]  push_addr, head_addr;
    logic [QDataW-1:0] q_head;
    pio_status_t       status;

    // configuration registers, row offset kept alongside the height
    assign cfg_ready = 1'b1;

    always_comb begin
        width_next      = width_reg;
        height_next     = height_reg;
        row_offset_next = row_offset_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    width_next = cfg_data;
                end
                REG_FRAME_HEIGHT: begin
                    height_next     = cfg_data;
                    row_offset_next = pio_row_offset(cfg_data);
                end
                default: begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= FRAME_WIDTH_RST;
            height_reg     <= FRAME_HEIGHT_RST;
            row_offset_reg <= pio_row_offset(FRAME_HEIGHT_RST);
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            row_offset_reg <= row_offset_next;
        end
    end

    assign cfg.width      = width_reg;
    assign cfg.height     = height_reg;
    assign cfg.row_offset = row_offset_reg;

    // front: accept and classify
    pio_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (AddrW)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_plane     (s_plane),
        .s_x_pos     (s_x_pos),
        .s_y_pos     (s_y_pos),
        .s_sample_in (s_sample_in),
        .cfg         (cfg),
        .queue_full  (q_full),
        .push        (push),
        .push_op     (push_op),
        .push_addr   (push_addr)
    );

    // decoupling queue
    pio_queue #(
        .DATA_W (QDataW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_op, push_addr}),
        .pop       (pop),
        .pop_data  (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_op   = pio_op_t'(q_head[QDataW-1:AddrW]);
    assign head_addr = q_head[AddrW-1:0];

    // back: store access and result output
    pio_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (AddrW)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (!q_empty),
        .head_op      (head_op),
        .head_addr    (head_addr),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_from_inset (m_from_inset),
        .m_out_plane  (m_out_plane),
        .status       (status)
    );

    // a replaced sample needs a stored inset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_from_inset |-> status.present)
        else $error("inset replacement before any inset sample was stored");

    // only real planes are ever replaced
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_from_inset |-> (m_out_plane == PLANE_Y || m_out_plane == PLANE_U ||
                                     m_out_plane == PLANE_V))
        else $error("invalid plane replaced from inset");

    // no result appears out of an empty pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_empty && !status.read_busy && !m_valid |=> !m_valid)
        else $error("result without a pending main sample");

    // the queue never takes a transaction while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("push into a full queue");

endmodule
